// ===== hw/rtl/acctc_pkg.sv =====
// Shared types, constants and fixed-point helpers of the altitude climb throttle controller.
package acctc_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned QmW   = 48;  // rounded Q16.16 product
  localparam int unsigned SumW  = 50;  // widest intermediate sum

  // register map, index = paddr[4:2]
  localparam logic [2:0] RegAltGain   = 3'd0;
  localparam logic [2:0] RegMaxClimb  = 3'd1;
  localparam logic [2:0] RegCruise    = 3'd2;
  localparam logic [2:0] RegClimbThr  = 3'd3;
  localparam logic [2:0] RegThrPgain  = 3'd4;
  localparam logic [2:0] RegThrIgain  = 3'd5;
  localparam logic [2:0] RegThrDgain  = 3'd6;
  localparam logic [2:0] RegPitchGain = 3'd7;

  localparam logic [30:0]        AltGainRst   = 31'd6554;
  localparam logic [30:0]        MaxClimbRst  = 31'd131072;
  localparam logic [16:0]        CruiseRst    = 17'd45875;
  localparam logic signed [31:0] ClimbThrRst  = 32'sd6554;
  localparam logic signed [31:0] ThrPgainRst  = 32'sd6554;
  localparam logic signed [31:0] ThrIgainRst  = 32'sd655;
  localparam logic signed [31:0] ThrDgainRst  = 32'sd0;
  localparam logic signed [31:0] PitchGainRst = 32'sd6554;

  localparam logic signed [32:0] IntBound     = 33'sd9830400;  // 150.0 in Q16.16
  localparam logic [13:0]        ThrFullScale = 14'd9600;
  localparam logic signed [SumW-1:0] ThrSatLimit = 50'sd65543;  // scaled value exceeds 9600

  typedef struct packed {
    logic signed [31:0] altitude_target;
    logic signed [31:0] pre_climb;
    logic signed [31:0] altitude_measured;
    logic signed [31:0] vertical_speed;
    logic signed [31:0] nav_pitch_offset;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] climb_target;
    logic [13:0]        throttle_command;
    logic signed [31:0] pitch_target;
    logic signed [31:0] altitude_error;
  } out_req_t;

  typedef struct packed {
    logic [30:0]        altitude_gain;
    logic [30:0]        max_climb_rate;
    logic [16:0]        cruise_throttle;
    logic signed [31:0] climb_throttle_gain;
    logic signed [31:0] throttle_pgain;
    logic signed [31:0] throttle_igain;
    logic signed [31:0] throttle_dgain;
    logic signed [31:0] pitch_climb_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_ALT, MUL_INT, MUL_CLB, MUL_PCH, MUL_DER, MUL_PID
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AE, ST_MALT, ST_WAIT1, ST_CLIMB, ST_ERR, ST_DERR,
    ST_MDER, ST_PITCH, ST_PID, ST_MPID, ST_WAIT2, ST_THR, ST_OUT
  } state_e;

  typedef struct packed {
    logic     ld_in;
    logic     ld_ae;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_climb;
    logic     ld_err;
    logic     ld_derr;   // also updates previous error, integral and P+I sum
    logic     ld_thr_acc;
    logic     ld_pitch;
    logic     ld_pid;
    logic     ld_thr;
    logic     ld_out;
  } cmd_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [31:0] r;
    if (&v[SumW-1:31] || ~|v[SumW-1:31]) r = v[31:0];
    else if (v[SumW-1])                  r = 32'sh8000_0000;
    else                                 r = 32'sh7fff_ffff;
    return r;
  endfunction

  // Q16.16 product rounding: add half, floor shift
  function automatic logic signed [QmW-1:0] rnd_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction

endpackage

// ===== hw/rtl/acctc_regs.sv =====
// APB register file holding the controller gains and limits.
module acctc_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [acctc_pkg::AddrW-1:0] paddr,
  input  logic [acctc_pkg::DataW-1:0] pwdata,
  output logic [acctc_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output acctc_pkg::cfg_t            cfg_o
);
  import acctc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegAltGain:   cfg_d.altitude_gain       = pwdata[30:0];
        RegMaxClimb:  cfg_d.max_climb_rate      = pwdata[30:0];
        RegCruise:    cfg_d.cruise_throttle     = pwdata[16:0];
        RegClimbThr:  cfg_d.climb_throttle_gain = pwdata;
        RegThrPgain:  cfg_d.throttle_pgain      = pwdata;
        RegThrIgain:  cfg_d.throttle_igain      = pwdata;
        RegThrDgain:  cfg_d.throttle_dgain      = pwdata;
        RegPitchGain: cfg_d.pitch_climb_gain    = pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAltGain:   prdata = {1'b0, cfg_q.altitude_gain};
      RegMaxClimb:  prdata = {1'b0, cfg_q.max_climb_rate};
      RegCruise:    prdata = {15'd0, cfg_q.cruise_throttle};
      RegClimbThr:  prdata = cfg_q.climb_throttle_gain;
      RegThrPgain:  prdata = cfg_q.throttle_pgain;
      RegThrIgain:  prdata = cfg_q.throttle_igain;
      RegThrDgain:  prdata = cfg_q.throttle_dgain;
      RegPitchGain: prdata = cfg_q.pitch_climb_gain;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.altitude_gain       <= AltGainRst;
      cfg_q.max_climb_rate      <= MaxClimbRst;
      cfg_q.cruise_throttle     <= CruiseRst;
      cfg_q.climb_throttle_gain <= ClimbThrRst;
      cfg_q.throttle_pgain      <= ThrPgainRst;
      cfg_q.throttle_igain      <= ThrIgainRst;
      cfg_q.throttle_dgain      <= ThrDgainRst;
      cfg_q.pitch_climb_gain    <= PitchGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/acctc_dp.sv =====
// Datapath: shared multiplier, rounding stage, loop state and result register.
module acctc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acctc_pkg::cfg_t      cfg_i,
  input  acctc_pkg::cmd_t      cmd_i,
  input  acctc_pkg::in_req_t   in_req_i,
  output acctc_pkg::out_req_t  out_req_o
);
  import acctc_pkg::*;

  in_req_t             in_q;
  logic signed [31:0]  ae_q, climb_q, err_q, derr_q, pid_q, pitch_q;
  logic signed [31:0]  prev_q, prev_d, integ_q, integ_d;
  logic signed [31:0]  ae_d, climb_d, err_d, derr_d, pid_d, pitch_d;
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  prod_q, prod_d;
  logic signed [QmW-1:0]  qm_q;
  logic signed [SumW-1:0] acc_q, acc_d, thr_acc_q, thr_acc_d, thr_q, thr_d;
  logic signed [32:0]  mx, c33, i33;
  logic [30:0]         scaled;
  logic [14:0]         scaled_hi;
  logic [13:0]         cmd_val;
  out_req_t            out_q;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_ALT: begin mul_a = {1'b0, cfg_i.altitude_gain}; mul_b = ae_q;    end
      MUL_INT: begin mul_a = cfg_i.throttle_igain;         mul_b = integ_q; end
      MUL_CLB: begin mul_a = cfg_i.climb_throttle_gain;    mul_b = climb_q; end
      MUL_PCH: begin mul_a = cfg_i.pitch_climb_gain;       mul_b = climb_q; end
      MUL_DER: begin mul_a = cfg_i.throttle_dgain;         mul_b = derr_q;  end
      MUL_PID: begin mul_a = cfg_i.throttle_pgain;         mul_b = pid_q;   end
      default: begin mul_a = '0;                           mul_b = '0;      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    ae_d = sat32(SumW'(in_q.altitude_target) - SumW'(in_q.altitude_measured));

    // outer loop: saturate then bound to +/- max climb
    mx  = {2'b00, cfg_i.max_climb_rate};
    c33 = 33'(sat32(SumW'(qm_q) + SumW'(in_q.pre_climb)));
    if (c33 > mx)       climb_d = mx[31:0];
    else if (c33 < -mx) climb_d = 32'((-mx));
    else                climb_d = c33[31:0];

    err_d  = sat32(SumW'(in_q.vertical_speed) - SumW'(climb_q));
    derr_d = sat32(SumW'(err_q) - SumW'(prev_q));
    acc_d  = SumW'(err_q) + SumW'(qm_q);

    i33 = 33'(integ_q) + 33'(err_q);
    if (i33 > IntBound)       integ_d = IntBound[31:0];
    else if (i33 < -IntBound) integ_d = 32'((-IntBound));
    else                      integ_d = i33[31:0];
    prev_d = err_q;

    thr_acc_d = SumW'({1'b0, cfg_i.cruise_throttle}) + SumW'(qm_q);
    pitch_d   = sat32(SumW'(qm_q) + SumW'(in_q.nav_pitch_offset));
    pid_d     = sat32(acc_q + SumW'(qm_q));
    thr_d     = thr_acc_q - SumW'(qm_q);
  end

  // throttle scaling; large values saturate before the narrow multiply
  always_comb begin
    scaled    = 31'(thr_q[16:0]) * 31'(ThrFullScale);
    scaled_hi = scaled[30:16];
    if (thr_q[SumW-1] || thr_q == '0)   cmd_val = '0;
    else if (thr_q >= ThrSatLimit)      cmd_val = ThrFullScale;
    else if (scaled_hi > 15'(ThrFullScale)) cmd_val = ThrFullScale;
    else                                cmd_val = scaled_hi[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      integ_q <= '0;
    end else if (cmd_i.ld_derr) begin
      prev_q  <= prev_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in)      in_q      <= in_req_i;
    if (cmd_i.ld_ae)      ae_q      <= ae_d;
    if (cmd_i.mul_en)     prod_q    <= prod_d;
    qm_q <= rnd_q16(prod_q);
    if (cmd_i.ld_climb)   climb_q   <= climb_d;
    if (cmd_i.ld_err)     err_q     <= err_d;
    if (cmd_i.ld_derr) begin
      derr_q <= derr_d;
      acc_q  <= acc_d;
    end
    if (cmd_i.ld_thr_acc) thr_acc_q <= thr_acc_d;
    if (cmd_i.ld_pitch)   pitch_q   <= pitch_d;
    if (cmd_i.ld_pid)     pid_q     <= pid_d;
    if (cmd_i.ld_thr)     thr_q     <= thr_d;
    if (cmd_i.ld_out) begin
      out_q.climb_target     <= climb_q;
      out_q.throttle_command <= cmd_val;
      out_q.pitch_target     <= pitch_q;
      out_q.altitude_error   <= ae_q;
    end
  end

  assign out_req_o = out_q;

endmodule

// ===== hw/rtl/acctc_ctrl.sv =====
// Sequencer: steps one request through the datapath and owns both handshakes.
module acctc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output acctc_pkg::cmd_t cmd_o
);
  import acctc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_ALT;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.ld_in = in_valid_i;
        if (in_valid_i) state_d = ST_AE;
      end
      ST_AE: begin
        cmd_o.ld_ae = 1'b1;
        state_d     = ST_MALT;
      end
      ST_MALT: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_WAIT1;
      end
      ST_WAIT1: state_d = ST_CLIMB;
      ST_CLIMB: begin
        cmd_o.ld_climb = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_INT;
        state_d        = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.ld_err  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_CLB;
        state_d       = ST_DERR;
      end
      ST_DERR: begin
        cmd_o.ld_derr = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PCH;
        state_d       = ST_MDER;
      end
      ST_MDER: begin
        cmd_o.ld_thr_acc = 1'b1;
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MUL_DER;
        state_d          = ST_PITCH;
      end
      ST_PITCH: begin
        cmd_o.ld_pitch = 1'b1;
        state_d        = ST_PID;
      end
      ST_PID: begin
        cmd_o.ld_pid = 1'b1;
        state_d      = ST_MPID;
      end
      ST_MPID: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PID;
        state_d       = ST_WAIT2;
      end
      ST_WAIT2: state_d = ST_THR;
      ST_THR: begin
        cmd_o.ld_thr = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.ld_out = can_load;
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.ld_out)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

  // an accepted request starts the sequence
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_AE))
    else $error("accepted request did not start the sequence");

  // loop state only moves once per request, after the error is known
  a_state_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_derr |-> ($past(cmd_o.ld_err) && $past(state_q, 6) == ST_IDLE))
    else $error("loop state updated out of sequence");

  // a result is dropped only when taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(out_ready_i))
    else $error("result withdrawn without being taken");

endmodule

// ===== hw/rtl/altitude_climb_throttle_controller.sv =====
// Top level of the cascaded altitude / climb-rate throttle controller.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   input    | in_valid_i / in_ready_o | in_req_i  (acctc_pkg::in_req_t)
//   output   | out_valid_o/ out_ready_i| out_req_o (acctc_pkg::out_req_t)
//   config   | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// One request is worked at a time, stepped to the result register by the
// state sequence around a single shared 32x32 multiplier with a registered
// product and a registered rounding stage. in_ready_o is high only while
// the sequencer idles, so a new request is taken only after the last one
// has been written to the result register.
// Reset (rst_ni, asynchronous, active low) loads the register defaults and
// clears the previous error and the integrator; no other sweep is needed.
// A stalled output holds the result register; the sequencer waits in its
// last state until the register frees, so no result is lost.
module altitude_climb_throttle_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request in
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  acctc_pkg::in_req_t          in_req_i,
  // result out
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output acctc_pkg::out_req_t         out_req_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acctc_pkg::AddrW-1:0] paddr,
  input  logic [acctc_pkg::DataW-1:0] pwdata,
  output logic [acctc_pkg::DataW-1:0] prdata,
  output logic                        pready
);
  import acctc_pkg::*;

  cfg_t cfg;   // live gains and limits
  cmd_t cmd;   // per-cycle datapath commands

  // register file; write it only while the block idles (the block itself does not enforce this)
  acctc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: altitude error, outer P loop, inner PID, pitch, throttle
  acctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath with the shared multiplier and the loop state
  acctc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .in_req_i  (in_req_i),
    .out_req_o (out_req_o)
  );

endmodule

// ===== bench/tb_altitude_climb_throttle_controller.sv =====
// Self-checking bench for the altitude climb throttle controller: directed and random ticks.
`timescale 1ns / 1ps

module tb_altitude_climb_throttle_controller;
  import acctc_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int ClkPeriodNs    = 4;
  localparam int ResetCycles    = 3;
  localparam int NumRegs        = 8;
  localparam int NumDirected    = 16;
  localparam int NumPhases      = 7;
  localparam int ItemsPerPhase  = 262;   // random requests per register setting
  localparam int SettleCycles   = 32;    // exceeds the time the sequencer takes per request
  localparam int StallLimit     = 4000;  // cycles with no handshake at all
  localparam int MaxReported    = 10;
  localparam int PressureAfter  = 300;   // requests accepted before the long hold-off
  localparam int PressureCycles = 400;

  localparam int     S32Max = 32'h7fff_ffff;
  localparam int     S32Min = 32'h8000_0000;
  localparam longint SatHi  = 64'sd2147483647;
  localparam longint SatLo  = -64'sd2147483648;

  // Register settings walked through, one per phase
  typedef enum int {
    CFG_RESET,       // leave reset values in place
    CFG_TYPICAL,     // plausible flight gains
    CFG_HIGH,        // every register at its top value
    CFG_LOW,         // unsigned at zero, signed gains most negative
    CFG_SCRAMBLE,    // raw random words
    CFG_HOT_CRUISE   // plausible gains, cruise throttle above 1.0
  } cfg_mode_e;

  localparam cfg_mode_e PhasePlan [NumPhases] = '{
    CFG_RESET, CFG_TYPICAL, CFG_HIGH, CFG_LOW, CFG_SCRAMBLE, CFG_HOT_CRUISE, CFG_TYPICAL
  };

  typedef struct {
    in_req_t  req;
    bit       known;  // want is written out by hand
    out_req_t want;
  } directed_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals, inputs driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_req_t          in_req_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_req_t         out_req_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  altitude_climb_throttle_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(ClkPeriodNs / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bench state: register shadow, controller memory, pending setpoints
  // ---------------------------------------------------------------------------
  logic [31:0] shadow_regs [NumRegs] = '{
    32'(AltGainRst), 32'(MaxClimbRst), 32'(CruiseRst), ClimbThrRst,
    ThrPgainRst, ThrIgainRst, ThrDgainRst, PitchGainRst
  };
  longint      last_climb_error   = 0;  // climb error of the previous tick
  longint      climb_error_sum    = 0;  // integrator, held to +/-150.0
  out_req_t    pending_setpoints[$];
  int unsigned requests_accepted  = 0;
  int unsigned failures           = 0;

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MaxReported) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Fixed-point mirror of the controller
  // ---------------------------------------------------------------------------
  function automatic longint sat_s32(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  function automatic longint clamp_mag(input longint v, input longint bound);
    if (v > bound) return bound;
    if (v < -bound) return -bound;
    return v;
  endfunction

  // Q16.16 product: exact, add half an lsb, floor shift (ties go up)
  function automatic longint q16_mul(input longint a, input longint b);
    longint prod;
    prod = a * b + 64'sd32768;
    return prod >>> 16;
  endfunction

  // One control tick: climb, throttle and pitch setpoints; updates the
  // previous error and the integrator exactly as the block does.
  function automatic out_req_t compute_throttle_setpoints(input in_req_t req);
    longint   alt_gain, climb_max, cruise, climb_thr_gain;
    longint   p_gain, i_gain, d_gain, pitch_gain;
    longint   alt_err, climb, err, derr, pid, thr, cmd, pitch;
    out_req_t res;
    alt_gain       = longint'(shadow_regs[RegAltGain]);
    climb_max      = longint'(shadow_regs[RegMaxClimb]);
    cruise         = longint'(shadow_regs[RegCruise]);
    climb_thr_gain = longint'($signed(shadow_regs[RegClimbThr]));
    p_gain         = longint'($signed(shadow_regs[RegThrPgain]));
    i_gain         = longint'($signed(shadow_regs[RegThrIgain]));
    d_gain         = longint'($signed(shadow_regs[RegThrDgain]));
    pitch_gain     = longint'($signed(shadow_regs[RegPitchGain]));

    // outer loop: altitude error to bounded climb setpoint
    alt_err = sat_s32(longint'(req.altitude_target) - longint'(req.altitude_measured));
    climb   = sat_s32(q16_mul(alt_gain, alt_err) + longint'(req.pre_climb));
    climb   = clamp_mag(climb, climb_max);

    // inner loop: PID on climb error, integrator term uses the old sum
    err  = sat_s32(longint'(req.vertical_speed) - climb);
    derr = sat_s32(err - last_climb_error);
    last_climb_error = err;
    pid  = sat_s32(err + q16_mul(i_gain, climb_error_sum) + q16_mul(d_gain, derr));
    thr  = cruise + q16_mul(climb_thr_gain, climb) - q16_mul(p_gain, pid);
    climb_error_sum = clamp_mag(climb_error_sum + err, longint'(IntBound));

    // throttle scaled to 0..full scale, truncated
    if (thr <= 0) begin
      cmd = 0;
    end else begin
      cmd = (thr * longint'(ThrFullScale)) >>> 16;
      if (cmd > longint'(ThrFullScale)) cmd = longint'(ThrFullScale);
    end

    pitch = sat_s32(q16_mul(pitch_gain, climb) + longint'(req.nav_pitch_offset));

    res.climb_target     = climb[31:0];
    res.throttle_command = cmd[13:0];
    res.pitch_target     = pitch[31:0];
    res.altitude_error   = alt_err[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_req_t make_tick(input int tgt, input int pre, input int meas,
                                        input int vz, input int nav);
    in_req_t r;
    r.altitude_target   = tgt;
    r.pre_climb         = pre;
    r.altitude_measured = meas;
    r.vertical_speed    = vz;
    r.nav_pitch_offset  = nav;
    return r;
  endfunction

  // Anything a 32-bit field can hold, with extra weight on the edges
  function automatic int noisy_word();
    int w;
    case ($urandom_range(0, 3))
      0, 1: w = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: w = S32Max;
          1: w = S32Min;
          2: w = 0;
          3: w = -1;
          default: w = 1;
        endcase
      end
      default: w = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
    return w;
  endfunction

  // Mostly flyable ticks (altitude within +/-1024 m, tracking error within
  // +/-50 m, modest speeds), the rest raw noise.
  function automatic in_req_t random_tick();
    int tgt;
    if ($urandom_range(0, 9) < 7) begin
      tgt = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      return make_tick(tgt,
                       int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000,
                       tgt + int'($urandom_range(0, 32'h0064_0000)) - 32'sh0032_0000,
                       int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000,
                       int'($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
    end
    return make_tick(noisy_word(), noisy_word(), noisy_word(), noisy_word(), noisy_word());
  endfunction

  function automatic logic [31:0] register_mask(input logic [2:0] idx);
    case (idx)
      RegAltGain, RegMaxClimb: return 32'h7fff_ffff;
      RegCruise:               return 32'h0001_ffff;
      default:                 return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] pick_register_value(input logic [2:0] idx,
                                                      input cfg_mode_e mode);
    logic [31:0] v;
    bit          is_unsigned;
    is_unsigned = idx inside {RegAltGain, RegMaxClimb, RegCruise};
    case (mode)
      // bits above each unsigned field are written too; the block drops them
      CFG_HIGH:     v = is_unsigned ? 32'hffff_ffff : 32'h7fff_ffff;
      CFG_LOW:      v = is_unsigned ? 32'h0000_0000 : 32'h8000_0000;
      CFG_SCRAMBLE: v = $urandom;
      default: begin
        case (idx)
          RegAltGain:  v = $urandom_range(0, 32'h0001_0000);
          RegMaxClimb: v = $urandom_range(0, 32'h0010_0000);
          RegCruise:   v = (mode == CFG_HOT_CRUISE) ? $urandom_range(65537, 131071)
                                                    : $urandom_range(0, 65536);
          default:     v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus and channel drivers
  // ---------------------------------------------------------------------------
  // Setup then access phase, then a bus idle before the task returns, so back-to-back
  // calls never schedule two updates of psel/penable in one step.
  task automatic apb_access(input bit is_write, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all registers for the given setting (none for CFG_RESET) and reads
  // every one back against the shadow copy.
  task automatic program_registers(input cfg_mode_e mode);
    logic [31:0] value;
    logic [31:0] readback;
    for (int idx = 0; idx < NumRegs; idx++) begin
      if (mode != CFG_RESET) begin
        value = pick_register_value(3'(idx), mode);
        apb_access(1'b1, 3'(idx), value, readback);
        shadow_regs[idx] = value & register_mask(3'(idx));
      end
      apb_access(1'b0, 3'(idx), '0, readback);
      if ((readback & register_mask(3'(idx))) !== shadow_regs[idx])
        note_failure($sformatf("register %0d reads %h, expected %h",
                               idx, readback, shadow_regs[idx]));
    end
  endtask

  // Offers one request and returns at the edge that accepts it; valid is left
  // high so the caller either chains the next request or drops it.
  task automatic send_request(input in_req_t req);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    requests_accepted++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest pending setpoint
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s: expected %h, got %h", name, want, got));
  endtask

  always @(posedge clk_i) begin : result_check
    out_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_setpoints.size() == 0) begin
        note_failure($sformatf("result %h with nothing pending", out_req_o));
      end else begin
        want = pending_setpoints.pop_front();
        compare_field("climb_target", want.climb_target, out_req_o.climb_target);
        compare_field("throttle_command", 32'(want.throttle_command),
                      32'(out_req_o.throttle_command));
        compare_field("pitch_target", want.pitch_target, out_req_o.pitch_target);
        compare_field("altitude_error", want.altitude_error, out_req_o.altitude_error);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if no handshake of any kind completes for too long
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: changing stall patterns, plus one long hold-off while the
  // sender keeps offering, so the block fills up and back-pressures its input
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned sink_mode;
    int unsigned span;
    logic [31:0] pattern;
    bit          ready;
    bit          pressure_done;
    pressure_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && requests_accepted >= PressureAfter) begin
        out_ready_i <= 1'b0;
        repeat (PressureCycles) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      sink_mode = $urandom_range(0, 3);
      span      = $urandom_range(8, 120);
      pattern   = $urandom;
      repeat (span) begin
        case (sink_mode)
          0: ready = 1'b1;                          // no stalls at all
          1: ready = 1'($urandom_range(0, 1));
          2: begin                                  // rotating bit mask
            ready   = pattern[0];
            pattern = {pattern[0], pattern[31:1]};
          end
          default: ready = ($urandom_range(0, 7) == 0);  // mostly stalled
        endcase
        out_ready_i <= ready;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    directed_row_t rows [NumDirected];
    out_req_t      predicted;
    in_req_t       tick;
    int unsigned   burst_left;

    // Directed ticks, run straight after reset with reset register values.
    // The first two are worked out by hand: all zero gives only the cruise
    // throttle (45875 * 9600 >> 16 = 6719); the widest altitude error pins
    // the climb setpoint at its bound and throttle at full scale.
    rows[0]  = '{make_tick(0, 0, 0, 0, 0), 1'b1,
                 out_req_t'{32'sd0, 14'd6719, 32'sd0, 32'sd0}};
    rows[1]  = '{make_tick(S32Max, 0, S32Min, 0, 0), 1'b1,
                 out_req_t'{32'sd131072, 14'd9600, 32'sd13108, 32'sh7fff_ffff}};
    // altitude error saturates low
    rows[2]  = '{make_tick(S32Min, 0, S32Max, 0, 0), 1'b0, '0};
    // feed-forward climb at both extremes: sum saturates, then bounded
    rows[3]  = '{make_tick(0, S32Max, 0, 0, 0), 1'b0, '0};
    rows[4]  = '{make_tick(0, S32Min, 0, 0, 0), 1'b0, '0};
    // climb error saturates high, throttle driven to zero
    rows[5]  = '{make_tick(0, S32Min, 0, S32Max, 0), 1'b0, '0};
    // climb error and its difference saturate low
    rows[6]  = '{make_tick(0, S32Max, 0, S32Min, 0), 1'b0, '0};
    // pitch setpoint saturates both ways
    rows[7]  = '{make_tick(0, S32Max, 0, 0, S32Max), 1'b0, '0};
    rows[8]  = '{make_tick(0, S32Min, 0, 0, S32Min), 1'b0, '0};
    // one lsb of altitude error
    rows[9]  = '{make_tick(0, 0, 1, 0, 0), 1'b0, '0};
    rows[10] = '{make_tick(-1, -1, -1, -1, -1), 1'b0, '0};
    rows[11] = '{make_tick(1, 1, 1, 1, 1), 1'b0, '0};
    // ordinary climb: 100 m wanted at 95 m, 0.5 m/s up
    rows[12] = '{make_tick(6553600, 16384, 6225920, 32768, 3277), 1'b0, '0};
    // large climb error twice, integrator runs into its bound, then swings
    rows[13] = '{make_tick(0, 0, 0, 13107200, 0), 1'b0, '0};
    rows[14] = '{make_tick(0, 0, 0, 13107200, 0), 1'b0, '0};
    rows[15] = '{make_tick(0, 0, 0, -13107200, 0), 1'b0, '0};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      // block is idle here: nothing pending and the settle time has passed
      program_registers(PhasePlan[phase]);

      if (phase == 0) begin
        for (int i = 0; i < NumDirected; i++) begin
          send_request(rows[i].req);
          predicted = compute_throttle_setpoints(rows[i].req);
          pending_setpoints.push_back(rows[i].known ? rows[i].want : predicted);
        end
      end

      // random requests in bursts; long bursts give stretches with no gaps
      burst_left = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        tick = random_tick();
        if (burst_left == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 24)) @(posedge clk_i);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
        end
        send_request(tick);
        pending_setpoints.push_back(compute_throttle_setpoints(tick));
        burst_left--;
      end
      in_valid_i <= 1'b0;

      while (pending_setpoints.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end

    if (pending_setpoints.size() != 0)
      note_failure($sformatf("%0d setpoints never arrived", pending_setpoints.size()));

    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acctc_pkg.sv
hw/rtl/acctc_regs.sv
hw/rtl/acctc_dp.sv
hw/rtl/acctc_ctrl.sv
hw/rtl/altitude_climb_throttle_controller.sv
bench/tb_altitude_climb_throttle_controller.sv
